// ===== sv/ppt_pkg.sv =====
// ----------------------------------------------------------------------------
// ppt_pkg
// shared types, widths and saturation helpers of the pocket perceptron trainer
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int FEATURE_BITS = 16;
  localparam int WEIGHT_BITS  = 40;
  localparam int LABEL_BITS   = 2;
  localparam int RATE_BITS    = 16;
  localparam int PROD_BITS    = RATE_BITS + 1 + FEATURE_BITS;   // eta * x
  localparam int DELTA_BITS   = PROD_BITS + 2;                  // times label
  localparam int SPROD_BITS   = FEATURE_BITS + WEIGHT_BITS;     // x * w
  localparam int SCORE_BITS   = 64;

  // register indexes
  localparam logic [1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [1:0] REG_FEAT_COUNT = 2'd1;
  localparam logic [1:0] REG_ITER_LIMIT = 2'd2;
  localparam logic [1:0] REG_PATIENCE   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic u_mul;
    logic u_add;
    logic s_mul;
    logic s_add;
    logic s_end;
    logic sum_clr;
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_inc;
    logic epoch;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sel;
    logic i_last;
    logic j_last;
    logic done;
  } sts_t;

  function automatic logic signed [WEIGHT_BITS-1:0] sat_weight(
    input logic signed [WEIGHT_BITS:0] v
  );
    logic signed [WEIGHT_BITS-1:0] r;
    if (v[WEIGHT_BITS] != v[WEIGHT_BITS-1]) begin
      r = {v[WEIGHT_BITS], {(WEIGHT_BITS-1){~v[WEIGHT_BITS]}}};
    end else begin
      r = v[WEIGHT_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SCORE_BITS-1:0] sat_score(
    input logic signed [SCORE_BITS:0] v
  );
    logic signed [SCORE_BITS-1:0] r;
    if (v[SCORE_BITS] != v[SCORE_BITS-1]) begin
      r = {v[SCORE_BITS], {(SCORE_BITS-1){~v[SCORE_BITS]}}};
    end else begin
      r = v[SCORE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/ppt_ram.sv =====
// ----------------------------------------------------------------------------
// ppt_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ppt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ppt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppt_ctrl
// sequencer for loading, the update and scoring passes, and the weight dump
// ----------------------------------------------------------------------------
module ppt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          in_set_end,
  input  logic          out_ready,
  input  ppt_pkg::sts_t sts,
  output ppt_pkg::cmd_t cmd,
  output logic          in_ready,
  output logic          out_valid
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_U_S   = 4'd1;
  localparam logic [3:0] ST_U_W   = 4'd2;
  localparam logic [3:0] ST_U_F   = 4'd3;
  localparam logic [3:0] ST_U_M   = 4'd4;
  localparam logic [3:0] ST_U_A   = 4'd5;
  localparam logic [3:0] ST_S_F   = 4'd6;
  localparam logic [3:0] ST_S_M   = 4'd7;
  localparam logic [3:0] ST_S_A   = 4'd8;
  localparam logic [3:0] ST_S_E   = 4'd9;
  localparam logic [3:0] ST_EPOCH = 4'd10;
  localparam logic [3:0] ST_EMIT  = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_fire;
        if (in_fire && in_set_end) begin
          cmd.start = 1'b1;
          state_nxt = ST_U_S;
        end
      end
      ST_U_S: state_nxt = ST_U_W;
      ST_U_W: begin
        if (sts.sel) begin
          state_nxt = ST_U_F;
        end else if (sts.i_last) begin
          cmd.i_clr   = 1'b1;
          cmd.sum_clr = 1'b1;
          state_nxt   = ST_S_F;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_U_S;
        end
      end
      ST_U_F: state_nxt = ST_U_M;
      ST_U_M: begin
        cmd.u_mul = 1'b1;
        state_nxt = ST_U_A;
      end
      ST_U_A: begin
        cmd.u_add = 1'b1;
        if (sts.j_last) begin
          cmd.j_clr = 1'b1;
          if (sts.i_last) begin
            cmd.i_clr   = 1'b1;
            cmd.sum_clr = 1'b1;
            state_nxt   = ST_S_F;
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = ST_U_S;
          end
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = ST_U_F;
        end
      end
      ST_S_F: state_nxt = ST_S_M;
      ST_S_M: begin
        cmd.s_mul = 1'b1;
        state_nxt = ST_S_A;
      end
      ST_S_A: begin
        cmd.s_add = 1'b1;
        if (sts.j_last) begin
          state_nxt = ST_S_E;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = ST_S_F;
        end
      end
      ST_S_E: begin
        cmd.s_end = 1'b1;
        cmd.j_clr = 1'b1;
        if (sts.i_last) begin
          cmd.i_clr = 1'b1;
          state_nxt = ST_EPOCH;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_S_F;
        end
      end
      ST_EPOCH: begin
        cmd.epoch = 1'b1;
        cmd.j_clr = 1'b1;
        state_nxt = sts.done ? ST_EMIT : ST_U_S;
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (sts.j_last) begin
            cmd.finish = 1'b1;
            cmd.j_clr  = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.j_inc = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/ppt_dp.sv =====
// ----------------------------------------------------------------------------
// ppt_dp
// sample stores, weight and pocket registers, multiply and accumulate
// ----------------------------------------------------------------------------
module ppt_dp #(
  parameter int MAX_FEATURES = 32,
  parameter int MAX_SAMPLES  = 4096
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  ppt_pkg::cmd_t                              cmd,
  output ppt_pkg::sts_t                              sts,
  input  logic                                       cfg_we,
  input  logic [1:0]                                 cfg_index,
  input  logic [15:0]                                cfg_wdata,
  input  logic signed [ppt_pkg::FEATURE_BITS-1:0]    in_feature,
  input  logic signed [ppt_pkg::LABEL_BITS-1:0]      in_label,
  input  logic                                       in_sample_end,
  input  logic                                       in_set_end,
  output logic [4:0]                                 out_weight_index,
  output logic signed [ppt_pkg::WEIGHT_BITS-1:0]     out_weight_value,
  output logic [15:0]                                out_epochs_run,
  output logic [12:0]                                out_missed_count,
  output logic                                       out_load_overflow
);

  localparam int JW     = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
  localparam int LW     = $clog2(MAX_FEATURES + 1);
  localparam int IW     = $clog2(MAX_SAMPLES);
  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int FDEPTH = MAX_SAMPLES * MAX_FEATURES;
  localparam int FA     = FDEPTH > 1 ? $clog2(FDEPTH) : 1;
  localparam int MW     = LW + ppt_pkg::LABEL_BITS;
  localparam int FB     = ppt_pkg::FEATURE_BITS;
  localparam int WB     = ppt_pkg::WEIGHT_BITS;

  // configuration
  logic [15:0] lr_r, lim_r;
  logic [5:0]  fc_r;
  logic [7:0]  pat_r;

  // loading
  logic [CW-1:0] cnt_r;
  logic [LW-1:0] pos_r;
  logic          ovf_r;

  // training
  logic [IW-1:0] i_r;
  logic [JW-1:0] j_r;
  logic [LW-1:0] d_r;
  logic          first_r, bestv_r;
  logic [CW-1:0] sum_r, best_r;
  logic [7:0]    stall_r;
  logic [15:0]   epoch_r;
  logic signed [ppt_pkg::PROD_BITS-1:0]  p_r;
  logic signed [ppt_pkg::SPROD_BITS-1:0] prod_r;
  logic signed [ppt_pkg::SCORE_BITS-1:0] score_r;
  logic signed [WB-1:0] w_r  [MAX_FEATURES];
  logic signed [WB-1:0] pk_r [MAX_FEATURES];

  // load path
  logic          room, pos_ok, end_el;
  logic [LW-1:0] pos_inc;
  logic [FA-1:0] f_waddr, f_raddr;

  assign room    = (cnt_r < CW'(MAX_SAMPLES));
  assign pos_ok  = (pos_r < LW'(MAX_FEATURES));
  assign pos_inc = pos_ok ? pos_r + LW'(1) : pos_r;
  assign end_el  = in_sample_end | in_set_end;
  assign f_waddr = FA'(FA'(cnt_r[IW-1:0]) * FA'(MAX_FEATURES)) + FA'(pos_r);
  assign f_raddr = FA'(FA'(i_r) * FA'(MAX_FEATURES)) + FA'(j_r);

  logic [FB-1:0] f_rdata;
  logic [MW-1:0] m_rdata;
  logic          miss_rdata, miss_now;

  ppt_ram #(.WIDTH(FB), .DEPTH(FDEPTH)) u_feat (
    .clk   (clk),
    .we    (cmd.load & room & pos_ok),
    .waddr (f_waddr),
    .wdata (in_feature),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // per sample: delivered feature count and label
  ppt_ram #(.WIDTH(MW), .DEPTH(MAX_SAMPLES)) u_meta (
    .clk   (clk),
    .we    (cmd.load & end_el & room),
    .waddr (cnt_r[IW-1:0]),
    .wdata ({pos_inc, in_label}),
    .raddr (i_r),
    .rdata (m_rdata)
  );

  ppt_ram #(.WIDTH(1), .DEPTH(MAX_SAMPLES)) u_miss (
    .clk   (clk),
    .we    (cmd.s_end),
    .waddr (i_r),
    .wdata (miss_now),
    .raddr (i_r),
    .rdata (miss_rdata)
  );

  logic [LW-1:0]                      m_len;
  logic signed [1:0]                  m_lab;
  logic signed [FB-1:0]               xm;
  logic signed [ppt_pkg::DELTA_BITS-1:0] delta;
  logic signed [WB:0]                 wsum;
  logic signed [ppt_pkg::SCORE_BITS:0] ssum;
  logic [LW-1:0]                      d_cfg;
  logic [15:0]                        lim_eff;
  logic                               better;

  assign m_len = m_rdata[MW-1:ppt_pkg::LABEL_BITS];
  assign m_lab = m_rdata[ppt_pkg::LABEL_BITS-1:0];
  // features past the delivered count read as zero
  assign xm    = (LW'(j_r) < m_len) ? f_rdata : '0;

  always_comb begin
    case (m_lab)
      2'sb01:  delta = ppt_pkg::DELTA_BITS'(p_r);
      2'sb11:  delta = -ppt_pkg::DELTA_BITS'(p_r);
      2'sb10:  delta = -(ppt_pkg::DELTA_BITS'(p_r) <<< 1);
      default: delta = '0;
    endcase
  end

  assign wsum = (WB+1)'(w_r[j_r]) + (WB+1)'(delta);
  assign ssum = (ppt_pkg::SCORE_BITS+1)'(score_r) + (ppt_pkg::SCORE_BITS+1)'(prod_r);

  always_comb begin
    if (m_lab == 2'sb01) begin
      miss_now = (score_r <= 0);
    end else if (m_lab[1]) begin
      miss_now = (score_r >= 0);
    end else begin
      miss_now = 1'b1;
    end
  end

  always_comb begin
    if (fc_r == 6'd0) begin
      d_cfg = LW'(1);
    end else if ({1'b0, fc_r} > 7'(MAX_FEATURES)) begin
      d_cfg = LW'(MAX_FEATURES);
    end else begin
      d_cfg = LW'(fc_r);
    end
  end

  assign lim_eff = (lim_r == 16'hFFFF) ? 16'hFFFE : lim_r;
  assign better  = !bestv_r || (sum_r < best_r);

  assign sts.sel    = first_r | miss_rdata;
  assign sts.i_last = ((CW+1)'(i_r) + (CW+1)'(1)) == (CW+1)'(cnt_r);
  assign sts.j_last = ((LW+1)'(j_r) + (LW+1)'(1)) == (LW+1)'(d_r);
  assign sts.done   = (sum_r == '0) || ((17'(epoch_r) + 17'd1) > 17'(lim_eff));

  assign out_weight_index  = 5'(j_r);
  assign out_weight_value  = w_r[j_r];
  assign out_epochs_run    = epoch_r;
  assign out_missed_count  = 13'(sum_r);
  assign out_load_overflow = ovf_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.u_mul) begin
      p_r <= ppt_pkg::PROD_BITS'($signed({1'b0, lr_r}) * xm);
    end
    if (cmd.s_mul) begin
      prod_r <= ppt_pkg::SPROD_BITS'(xm * w_r[j_r]);
    end
    if (cmd.start || cmd.s_end) begin
      score_r <= '0;
    end else if (cmd.s_add) begin
      score_r <= ppt_pkg::sat_score(ssum);
    end
    for (int k = 0; k < MAX_FEATURES; k++) begin
      if (cmd.start) begin
        w_r[k] <= '0;
      end else if (cmd.epoch && better) begin
        pk_r[k] <= w_r[k];
      end else if (cmd.epoch && stall_r >= pat_r) begin
        w_r[k] <= pk_r[k];
      end
    end
    if (cmd.u_add) begin
      w_r[j_r] <= ppt_pkg::sat_weight(wsum);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= 16'd6554;
      fc_r    <= 6'd23;
      lim_r   <= 16'd10000;
      pat_r   <= 8'd10;
      cnt_r   <= '0;
      pos_r   <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      d_r     <= LW'(1);
      first_r <= 1'b1;
      bestv_r <= 1'b0;
      best_r  <= '0;
      sum_r   <= '0;
      stall_r <= '0;
      epoch_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ppt_pkg::REG_LEARN_RATE: lr_r  <= cfg_wdata;
          ppt_pkg::REG_FEAT_COUNT: fc_r  <= cfg_wdata[5:0];
          ppt_pkg::REG_ITER_LIMIT: lim_r <= cfg_wdata;
          ppt_pkg::REG_PATIENCE:   pat_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (end_el) begin
          pos_r <= '0;
          if (room) begin
            cnt_r <= cnt_r + CW'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end else begin
          pos_r <= pos_inc;
        end
      end
      if (cmd.finish) begin
        cnt_r <= '0;
        pos_r <= '0;
        ovf_r <= 1'b0;
      end
      if (cmd.start) begin
        d_r     <= d_cfg;
        first_r <= 1'b1;
        bestv_r <= 1'b0;
        best_r  <= '0;
        stall_r <= '0;
        epoch_r <= '0;
        sum_r   <= '0;
        i_r     <= '0;
        j_r     <= '0;
      end
      if (cmd.i_clr) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + IW'(1);
      end
      if (cmd.j_clr) begin
        j_r <= '0;
      end else if (cmd.j_inc) begin
        j_r <= j_r + JW'(1);
      end
      if (cmd.sum_clr) begin
        sum_r <= '0;
      end else if (cmd.s_end && miss_now) begin
        sum_r <= sum_r + CW'(1);
      end
      if (cmd.epoch) begin
        first_r <= 1'b0;
        epoch_r <= epoch_r + 16'd1;
        if (better) begin
          bestv_r <= 1'b1;
          best_r  <= sum_r;
          stall_r <= '0;
        end else if (stall_r != 8'hFF) begin
          stall_r <= stall_r + 8'd1;
        end
      end
    end
  end

endmodule

// ===== sv/pocket_perceptron_trainer_unit.sv =====
// ----------------------------------------------------------------------------
// pocket_perceptron_trainer_unit
// pocket perceptron batch trainer with on-chip sample store
// ----------------------------------------------------------------------------
// Samples stream in one feature word per cycle (tlast closes a sample, tuser
// closes the set) and are kept in a block ram of MAX_SAMPLES x MAX_FEATURES
// words. The word that closes the set starts training, during which no input
// is taken. Each epoch, for d features in use, runs an update pass that skips
// samples that were not missed and walks the d features of each missed one,
// one feature a step, then a scoring pass over every sample, then the pocket
// step. The d weights then leave one word per cycle while out_tready is high.
// No clearing pass is needed.
// ----------------------------------------------------------------------------
module pocket_perceptron_trainer_unit #(
  parameter int MAX_FEATURES = 32,
  parameter int MAX_SAMPLES  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // feature[15:0], label[17:16], zero pad
  input  logic        in_tlast,   // sample end
  input  logic        in_tuser,   // set end
  // weight stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // weight_index[4:0], weight_value[44:5],
                                  // epochs_run[60:45], missed_count[73:61], zero pad
  output logic        out_tlast,  // final weight of the run
  output logic        out_tuser   // load overflow
);

  ppt_pkg::cmd_t cmd;
  ppt_pkg::sts_t sts;
  logic          in_fire;
  logic [4:0]    w_idx;
  logic signed [ppt_pkg::WEIGHT_BITS-1:0] w_val;
  logic [15:0]   ep;
  logic [12:0]   miss;

  assign in_fire = in_tvalid & in_tready;

  ppt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_set_end (in_tuser),
    .out_ready  (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid)
  );

  ppt_dp #(
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_feature        (in_tdata[15:0]),
    .in_label          (in_tdata[17:16]),
    .in_sample_end     (in_tlast),
    .in_set_end        (in_tuser),
    .out_weight_index  (w_idx),
    .out_weight_value  (w_val),
    .out_epochs_run    (ep),
    .out_missed_count  (miss),
    .out_load_overflow (out_tuser)
  );

  // last weight is flagged by the same compare that ends the dump
  assign out_tlast = sts.j_last;
  assign out_tdata = {6'd0, miss, ep, w_val, w_idx};

endmodule
